FILE: rtl/core/apsp_pkg.sv
// Shared constants, types and helpers for the all-pairs shortest path solver.
package apsp_pkg;

  localparam int NUM_VERTICES = 8;
  localparam int WEIGHT_BITS  = 16;

  localparam int IN_VTX_W    = 3;
  localparam int IN_WEIGHT_W = 16;
  localparam int OUT_DIST_W  = 19;
  localparam int OUT_VTX_W   = 3;

  localparam int VTX_W  = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int CELL_W = 2 * VTX_W;
  localparam int CELLS  = 1 << CELL_W;
  // A simple path uses fewer edges than there are vertices, so this width never overflows.
  localparam int DIST_W = WEIGHT_BITS + VTX_W;

  typedef logic [VTX_W-1:0]       vtx_t;
  typedef logic [CELL_W-1:0]      cell_t;
  typedef logic [DIST_W-1:0]      dist_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;

  localparam vtx_t VTX_LAST = vtx_t'(NUM_VERTICES - 1);

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_DROP_V = 3'd2,
    REQ_SOLVE  = 3'd3,
    REQ_QUERY  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_COL,
    ST_QUERY,
    ST_RESP
  } seq_state_t;

  typedef struct packed {
    dist_t cost;
    vtx_t  hop;
  } path_entry_t;

  typedef struct packed {
    logic busy;
    logic init_issue;
    logic row_issue;
    logic col_issue;
    logic cap_row;
    logic query_issue;
    logic resp;
    vtx_t i;
    vtx_t j;
    vtx_t k;
  } seq_ctl_t;

  typedef struct packed {
    logic        upd;
    path_entry_t entry;
  } relax_res_t;

  function automatic vtx_t to_vtx(input logic [IN_VTX_W-1:0] v);
    return vtx_t'(v);
  endfunction

  function automatic cell_t cell_of(input vtx_t r, input vtx_t c);
    return {r, c};
  endfunction

  // Edge weights are symmetric, so only one cell of each pair is stored.
  function automatic cell_t canon_cell(input vtx_t x, input vtx_t y);
    return (x < y) ? {x, y} : {y, x};
  endfunction

endpackage

FILE: rtl/core/all_pairs_shortest_path_solver.sv
// Top level of the all-pairs shortest path solver: edge store, path flags and result.
//
// Usage: drive in_req_type, in_vertex_a, in_vertex_b and in_weight and raise start
// while busy is low; the request is taken at that clock edge. Every request gives
// exactly one result, shown on the out_ ports for one cycle with out_strobe high.
// Edge edits and unknown requests go straight to the response state; a query
// first reads the path memory in a query state. A solve first copies the edge
// table into the path memory, one pair per cycle, then walks pivots k and rows
// i and, for rows that reach the pivot, does one relaxation per cycle on the
// shared add-and-compare unit. out_strobe is registered from the response
// state. busy stays high until the result has been formed, and a new request
// may be taken in the cycle that shows the result. The receiver cannot stall,
// so results are never held back. Reset clears the edge and reachability
// flags: nothing is reachable before the first solve.
module all_pairs_shortest_path_solver (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      in_req_type,
  input  logic [apsp_pkg::IN_VTX_W-1:0]   in_vertex_a,
  input  logic [apsp_pkg::IN_VTX_W-1:0]   in_vertex_b,
  input  logic [apsp_pkg::IN_WEIGHT_W-1:0] in_weight,
  output logic                            out_strobe,
  output logic [apsp_pkg::OUT_DIST_W-1:0] out_distance,
  output logic                            out_reachable,
  output logic [apsp_pkg::OUT_VTX_W-1:0]  out_next_vertex,
  output logic                            out_next_valid
);

  apsp_pkg::seq_ctl_t ctl;
  logic               start_acc;
  apsp_pkg::req_t     req_in;

  logic a_ok;
  logic b_ok;
  apsp_pkg::vtx_t va;
  apsp_pkg::vtx_t vb;

  logic [apsp_pkg::CELLS-1:0] edge_present_r, edge_present_nxt;
  logic [apsp_pkg::CELLS-1:0] path_known_r;
  logic [apsp_pkg::CELLS-1:0] known_init;

  apsp_pkg::weight_t weight_mem [apsp_pkg::CELLS];
  apsp_pkg::weight_t w_rd_r;

  // Request held for the whole of its processing.
  apsp_pkg::req_t req_r;
  apsp_pkg::vtx_t a_r;
  apsp_pkg::vtx_t b_r;
  logic           ok_r;

  // Copy sweep write, in the cycle after the weight read.
  logic           init_v_r;
  apsp_pkg::vtx_t init_i_r;
  apsp_pkg::vtx_t init_j_r;

  // Relaxation stage, in the cycle after the path memory reads.
  logic           rlx_v_r;
  apsp_pkg::vtx_t rlx_i_r;
  apsp_pkg::vtx_t rlx_j_r;
  apsp_pkg::vtx_t rlx_k_r;
  apsp_pkg::path_entry_t row_r;

  apsp_pkg::path_entry_t rd0_data;
  apsp_pkg::path_entry_t rd1_data;
  apsp_pkg::cell_t       rd1_addr;
  apsp_pkg::relax_res_t  rlx;

  logic                  pm_wr_en;
  apsp_pkg::cell_t       pm_wr_addr;
  apsp_pkg::path_entry_t pm_wr_data;

  logic                            out_strobe_r;
  logic [apsp_pkg::OUT_DIST_W-1:0] out_distance_r;
  logic                            out_reachable_r;
  logic [apsp_pkg::OUT_VTX_W-1:0]  out_next_vertex_r;
  logic                            out_next_valid_r;

  logic q_hit;

  assign busy      = ctl.busy;
  assign start_acc = start && !ctl.busy;
  assign req_in    = apsp_pkg::req_t'(in_req_type);
  assign a_ok      = int'(in_vertex_a) < apsp_pkg::NUM_VERTICES;
  assign b_ok      = int'(in_vertex_b) < apsp_pkg::NUM_VERTICES;
  assign va        = apsp_pkg::to_vtx(in_vertex_a);
  assign vb        = apsp_pkg::to_vtx(in_vertex_b);

  apsp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_acc (start_acc),
    .req       (req_in),
    .known_ik  (path_known_r[apsp_pkg::cell_of(ctl.i, ctl.k)]),
    .ctl       (ctl)
  );

  // Edge flag edits; a vertex removal clears its whole row and column.
  always_comb begin
    edge_present_nxt = edge_present_r;
    if (start_acc) begin
      case (req_in)
        apsp_pkg::REQ_INSERT: begin
          if (a_ok && b_ok && va != vb) begin
            edge_present_nxt[apsp_pkg::cell_of(va, vb)] = 1'b1;
            edge_present_nxt[apsp_pkg::cell_of(vb, va)] = 1'b1;
          end
        end
        apsp_pkg::REQ_REMOVE: begin
          if (a_ok && b_ok && va != vb) begin
            edge_present_nxt[apsp_pkg::cell_of(va, vb)] = 1'b0;
            edge_present_nxt[apsp_pkg::cell_of(vb, va)] = 1'b0;
          end
        end
        apsp_pkg::REQ_DROP_V: begin
          if (a_ok) begin
            for (int c = 0; c < apsp_pkg::CELLS; c++) begin
              if (apsp_pkg::vtx_t'(c >> apsp_pkg::VTX_W) == va ||
                  apsp_pkg::vtx_t'(c) == va) begin
                edge_present_nxt[c] = 1'b0;
              end
            end
          end
        end
        default: edge_present_nxt = edge_present_r;
      endcase
    end
  end

  // At the start of a solve every vertex reaches itself and its direct neighbours.
  always_comb begin
    for (int c = 0; c < apsp_pkg::CELLS; c++) begin
      known_init[c] = edge_present_r[c] ||
                      ((apsp_pkg::vtx_t'(c >> apsp_pkg::VTX_W) == apsp_pkg::vtx_t'(c)) &&
                       ((c >> apsp_pkg::VTX_W) < apsp_pkg::NUM_VERTICES));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_present_r <= '0;
      path_known_r   <= '0;
    end else begin
      edge_present_r <= edge_present_nxt;
      if (start_acc && req_in == apsp_pkg::REQ_SOLVE) begin
        path_known_r <= known_init;
      end else if (rlx.upd) begin
        path_known_r[apsp_pkg::cell_of(rlx_i_r, rlx_j_r)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_acc && req_in == apsp_pkg::REQ_INSERT && a_ok && b_ok && va != vb) begin
      weight_mem[apsp_pkg::canon_cell(va, vb)] <= apsp_pkg::weight_t'(in_weight);
    end
    if (ctl.init_issue) begin
      w_rd_r <= weight_mem[apsp_pkg::canon_cell(ctl.i, ctl.j)];
    end
  end

  always_ff @(posedge clk) begin
    if (start_acc) begin
      req_r <= req_in;
      a_r   <= va;
      b_r   <= vb;
      ok_r  <= a_ok && b_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_v_r <= 1'b0;
      rlx_v_r  <= 1'b0;
    end else begin
      init_v_r <= ctl.init_issue;
      rlx_v_r  <= ctl.col_issue;
    end
  end

  always_ff @(posedge clk) begin
    init_i_r <= ctl.i;
    init_j_r <= ctl.j;
    rlx_i_r  <= ctl.i;
    rlx_j_r  <= ctl.j;
    rlx_k_r  <= ctl.k;
    if (ctl.cap_row) begin
      row_r <= rd1_data;
    end
  end

  always_comb begin
    if (ctl.query_issue) begin
      rd1_addr = apsp_pkg::cell_of(a_r, b_r);
    end else if (ctl.row_issue) begin
      rd1_addr = apsp_pkg::cell_of(ctl.i, ctl.k);
    end else begin
      rd1_addr = apsp_pkg::cell_of(ctl.i, ctl.j);
    end
  end

  apsp_relax u_relax (
    .active   (rlx_v_r),
    .diag     (rlx_i_r == rlx_j_r),
    .known_kj (path_known_r[apsp_pkg::cell_of(rlx_k_r, rlx_j_r)]),
    .known_ij (path_known_r[apsp_pkg::cell_of(rlx_i_r, rlx_j_r)]),
    .ik       (row_r),
    .kj       (rd0_data),
    .ij       (rd1_data),
    .res      (rlx)
  );

  always_comb begin
    pm_wr_en   = init_v_r || rlx.upd;
    pm_wr_addr = apsp_pkg::cell_of(rlx_i_r, rlx_j_r);
    pm_wr_data = rlx.entry;
    if (init_v_r) begin
      pm_wr_addr      = apsp_pkg::cell_of(init_i_r, init_j_r);
      pm_wr_data.hop  = init_j_r;
      pm_wr_data.cost = (init_i_r == init_j_r) ? '0 : apsp_pkg::dist_t'(w_rd_r);
    end
  end

  apsp_path_mem u_path_mem (
    .clk      (clk),
    .wr_en    (pm_wr_en),
    .wr_addr  (pm_wr_addr),
    .wr_data  (pm_wr_data),
    .rd0_en   (ctl.col_issue),
    .rd0_addr (apsp_pkg::cell_of(ctl.k, ctl.j)),
    .rd0_data (rd0_data),
    .rd1_en   (ctl.row_issue || ctl.col_issue || ctl.query_issue),
    .rd1_addr (rd1_addr),
    .rd1_data (rd1_data)
  );

  assign q_hit = (req_r == apsp_pkg::REQ_QUERY) && ok_r &&
                 path_known_r[apsp_pkg::cell_of(a_r, b_r)];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctl.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.resp) begin
      out_distance_r    <= q_hit ? apsp_pkg::OUT_DIST_W'(rd1_data.cost) : '0;
      out_reachable_r   <= q_hit;
      out_next_vertex_r <= (q_hit && a_r != b_r) ? apsp_pkg::OUT_VTX_W'(rd1_data.hop) : '0;
      out_next_valid_r  <= q_hit && (a_r != b_r);
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_distance    = out_distance_r;
  assign out_reachable   = out_reachable_r;
  assign out_next_vertex = out_next_vertex_r;
  assign out_next_valid  = out_next_valid_r;

  // The copy sweep and the relaxation walk must never share the write port.
  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(init_v_r && rlx_v_r))
    else $error("copy sweep and relaxation both write the path memory");

  // A relaxation never rewrites the distance of a vertex to itself.
  a_no_diag_update: assert property (@(posedge clk) disable iff (!rst_n)
    rlx.upd |-> (rlx_i_r != rlx_j_r))
    else $error("relaxation updated a same-vertex pair");

  // Each result follows a cycle in which the block was still busy with its request.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result shown without a request in progress");

  // A taken request always makes the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

endmodule

FILE: rtl/core/apsp_path_mem.sv
// Path table memory: distance and next hop per vertex pair, two read ports.
module apsp_path_mem (
  input  logic                 clk,
  input  logic                 wr_en,
  input  apsp_pkg::cell_t      wr_addr,
  input  apsp_pkg::path_entry_t wr_data,
  input  logic                 rd0_en,
  input  apsp_pkg::cell_t      rd0_addr,
  output apsp_pkg::path_entry_t rd0_data,
  input  logic                 rd1_en,
  input  apsp_pkg::cell_t      rd1_addr,
  output apsp_pkg::path_entry_t rd1_data
);

  apsp_pkg::path_entry_t mem [apsp_pkg::CELLS];
  apsp_pkg::path_entry_t rd0_r;
  apsp_pkg::path_entry_t rd1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd0_en) begin
      rd0_r <= mem[rd0_addr];
    end
    if (rd1_en) begin
      rd1_r <= mem[rd1_addr];
    end
  end

  assign rd0_data = rd0_r;
  assign rd1_data = rd1_r;

endmodule

FILE: rtl/core/apsp_relax.sv
// Shared relaxation unit: one add and one compare for a single pair.
module apsp_relax (
  input  logic                  active,
  input  logic                  diag,
  input  logic                  known_kj,
  input  logic                  known_ij,
  input  apsp_pkg::path_entry_t ik,
  input  apsp_pkg::path_entry_t kj,
  input  apsp_pkg::path_entry_t ij,
  output apsp_pkg::relax_res_t  res
);

  logic [apsp_pkg::DIST_W:0] via;
  logic                      shorter;

  assign via     = {1'b0, ik.cost} + {1'b0, kj.cost};
  assign shorter = !known_ij || ({1'b0, ij.cost} > via);

  always_comb begin
    res.upd        = active && !diag && known_kj && shorter;
    res.entry.cost = apsp_pkg::DIST_W'(via);
    res.entry.hop  = ik.hop;
  end

endmodule

FILE: rtl/core/apsp_seq.sv
// Sequencer: request dispatch, table copy sweep and the k/i/j relaxation walk.
module apsp_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_acc,
  input  apsp_pkg::req_t     req,
  input  logic               known_ik,
  output apsp_pkg::seq_ctl_t ctl
);

  apsp_pkg::seq_state_t state_r, state_nxt;
  apsp_pkg::vtx_t       i_r, i_nxt;
  apsp_pkg::vtx_t       j_r, j_nxt;
  apsp_pkg::vtx_t       k_r, k_nxt;

  logic i_last;
  logic j_last;
  logic k_last;

  assign i_last = (i_r == apsp_pkg::VTX_LAST);
  assign j_last = (j_r == apsp_pkg::VTX_LAST);
  assign k_last = (k_r == apsp_pkg::VTX_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apsp_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    case (state_r)
      apsp_pkg::ST_IDLE: begin
        i_nxt = '0;
        j_nxt = '0;
        k_nxt = '0;
        if (start_acc) begin
          case (req)
            apsp_pkg::REQ_SOLVE: state_nxt = apsp_pkg::ST_INIT;
            apsp_pkg::REQ_QUERY: state_nxt = apsp_pkg::ST_QUERY;
            default:             state_nxt = apsp_pkg::ST_RESP;
          endcase
        end
      end
      apsp_pkg::ST_INIT: begin
        if (j_last) begin
          j_nxt = '0;
          if (i_last) begin
            i_nxt     = '0;
            state_nxt = apsp_pkg::ST_ROW;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      apsp_pkg::ST_ROW, apsp_pkg::ST_COL: begin
        // A row is walked only when vertex i already reaches the pivot k.
        if (state_r == apsp_pkg::ST_ROW && known_ik) begin
          j_nxt     = '0;
          state_nxt = apsp_pkg::ST_COL;
        end else if (state_r == apsp_pkg::ST_COL && !j_last) begin
          j_nxt = j_r + 1'b1;
        end else if (i_last) begin
          i_nxt = '0;
          if (k_last) begin
            state_nxt = apsp_pkg::ST_RESP;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = apsp_pkg::ST_ROW;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = apsp_pkg::ST_ROW;
        end
      end
      apsp_pkg::ST_QUERY: state_nxt = apsp_pkg::ST_RESP;
      apsp_pkg::ST_RESP:  state_nxt = apsp_pkg::ST_IDLE;
      default:            state_nxt = apsp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    ctl.busy = (state_r != apsp_pkg::ST_IDLE);
    ctl.i    = i_r;
    ctl.j    = j_r;
    ctl.k    = k_r;
    case (state_r)
      apsp_pkg::ST_INIT:  ctl.init_issue = 1'b1;
      apsp_pkg::ST_ROW:   ctl.row_issue  = known_ik;
      apsp_pkg::ST_COL: begin
        ctl.col_issue = 1'b1;
        ctl.cap_row   = (j_r == '0);
      end
      apsp_pkg::ST_QUERY: ctl.query_issue = 1'b1;
      apsp_pkg::ST_RESP:  ctl.resp        = 1'b1;
      default:            ctl.busy        = (state_r != apsp_pkg::ST_IDLE);
    endcase
  end

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the shortest path solver: random graph edits, solves, queries.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TARGET_REQUESTS = 1170;
  localparam int          STALL_LIMIT     = 4000;
  localparam int          SETTLE_CYCLES   = 20;
  localparam int          MAX_REPORTS     = 200;
  localparam int          LEN_W           = apsp_pkg::OUT_DIST_W + 1;
  localparam logic [2:0]  REQ_SPARE_LO    = 3'd5;
  localparam logic [2:0]  REQ_SPARE_HI    = 3'd7;

  typedef struct packed {
    logic [2:0]        kind;
    apsp_pkg::vtx_t    a;
    apsp_pkg::vtx_t    b;
    apsp_pkg::weight_t w;
  } request_t;

  typedef struct packed {
    logic [apsp_pkg::OUT_DIST_W-1:0] cost;
    logic                            reach;
    logic [apsp_pkg::OUT_VTX_W-1:0]  hop;
    logic                            hop_ok;
  } answer_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             start = 1'b0;
  logic [2:0]                       in_req_type = '0;
  logic [apsp_pkg::IN_VTX_W-1:0]    in_vertex_a = '0;
  logic [apsp_pkg::IN_VTX_W-1:0]    in_vertex_b = '0;
  logic [apsp_pkg::IN_WEIGHT_W-1:0] in_weight = '0;
  logic                             busy;
  logic                             out_strobe;
  logic [apsp_pkg::OUT_DIST_W-1:0]  out_distance;
  logic                             out_reachable;
  logic [apsp_pkg::OUT_VTX_W-1:0]   out_next_vertex;
  logic                             out_next_valid;

  // Graph as edited, and the path tables left by the last solve.
  bit                 edge_on  [apsp_pkg::NUM_VERTICES][apsp_pkg::NUM_VERTICES];
  apsp_pkg::weight_t  edge_len [apsp_pkg::NUM_VERTICES][apsp_pkg::NUM_VERTICES];
  bit                 path_on  [apsp_pkg::NUM_VERTICES][apsp_pkg::NUM_VERTICES];
  logic [LEN_W-1:0]   path_len [apsp_pkg::NUM_VERTICES][apsp_pkg::NUM_VERTICES];
  apsp_pkg::vtx_t     path_hop [apsp_pkg::NUM_VERTICES][apsp_pkg::NUM_VERTICES];

  request_t               request_q[$];
  answer_t                answer_q[$];
  time                    answer_at[$];
  request_t               current;
  int                     requests_taken = 0;
  int                     mismatches = 0;
  int                     stall_cycles = 0;

  all_pairs_shortest_path_solver dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_vertex_a     (in_vertex_a),
    .in_vertex_b     (in_vertex_b),
    .in_weight       (in_weight),
    .out_strobe      (out_strobe),
    .out_distance    (out_distance),
    .out_reachable   (out_reachable),
    .out_next_vertex (out_next_vertex),
    .out_next_valid  (out_next_valid)
  );

  initial forever #10 clk = ~clk;

  function automatic answer_t graph_answer(input request_t r);
    answer_t          ans;
    logic [LEN_W-1:0] via;
    ans = '0;
    case (r.kind)
      apsp_pkg::REQ_INSERT: if (r.a != r.b) begin
        edge_on[r.a][r.b]  = 1'b1;
        edge_on[r.b][r.a]  = 1'b1;
        edge_len[r.a][r.b] = r.w;
        edge_len[r.b][r.a] = r.w;
      end
      apsp_pkg::REQ_REMOVE: if (r.a != r.b) begin
        edge_on[r.a][r.b] = 1'b0;
        edge_on[r.b][r.a] = 1'b0;
      end
      apsp_pkg::REQ_DROP_V: begin
        for (int v = 0; v < apsp_pkg::NUM_VERTICES; v++) begin
          edge_on[r.a][v] = 1'b0;
          edge_on[v][r.a] = 1'b0;
        end
      end
      apsp_pkg::REQ_SOLVE: begin
        for (int i = 0; i < apsp_pkg::NUM_VERTICES; i++) begin
          for (int j = 0; j < apsp_pkg::NUM_VERTICES; j++) begin
            path_on[i][j]  = (i == j) || edge_on[i][j];
            path_len[i][j] = (i != j && edge_on[i][j]) ? LEN_W'(edge_len[i][j]) : '0;
            path_hop[i][j] = (i != j && edge_on[i][j]) ? apsp_pkg::vtx_t'(j) : '0;
          end
        end
        // Only a strictly shorter route replaces a known one, so ties keep the older hop.
        for (int k = 0; k < apsp_pkg::NUM_VERTICES; k++) begin
          for (int i = 0; i < apsp_pkg::NUM_VERTICES; i++) begin
            if (path_on[i][k]) begin
              for (int j = 0; j < apsp_pkg::NUM_VERTICES; j++) begin
                if (i != j && path_on[k][j]) begin
                  via = path_len[i][k] + path_len[k][j];
                  if (!path_on[i][j] || path_len[i][j] > via) begin
                    path_on[i][j]  = 1'b1;
                    path_len[i][j] = via;
                    path_hop[i][j] = path_hop[i][k];
                  end
                end
              end
            end
          end
        end
      end
      apsp_pkg::REQ_QUERY: if (path_on[r.a][r.b]) begin
        ans.cost  = path_len[r.a][r.b][apsp_pkg::OUT_DIST_W-1:0];
        ans.reach = 1'b1;
        if (r.a != r.b) begin
          ans.hop    = path_hop[r.a][r.b];
          ans.hop_ok = 1'b1;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic push_req(input logic [2:0] kind, input int a, input int b, input int w);
    request_t r;
    r.kind = kind;
    r.a    = apsp_pkg::vtx_t'(a);
    r.b    = apsp_pkg::vtx_t'(b);
    r.w    = apsp_pkg::weight_t'(w);
    request_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Driver: holds a request on the inputs until it is taken, then moves to the next one.
  always @(posedge clk) begin : drive_proc
    bit taken;
    bit quiet;
    taken = 1'b0;
    quiet = (requests_taken >= 400) && (requests_taken < 700);
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        taken = 1'b1;
        answer_q.push_back(graph_answer(current));
        answer_at.push_back($time);
        requests_taken++;
      end
      if (!start || taken) begin
        if (request_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 14)) begin
          current = request_q.pop_front();
          start       <= 1'b1;
          in_req_type <= current.kind;
          in_vertex_a <= current.a;
          in_vertex_b <= current.b;
          in_weight   <= current.w;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: a result may only match a request taken at an earlier edge.
  always @(posedge clk) begin : check_proc
    answer_t want;
    if (rst_n && out_strobe) begin
      if (answer_q.size() == 0 || answer_at[0] == $time) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $error("result with no request outstanding: distance %0d reachable %0b",
                 out_distance, out_reachable);
      end else begin
        want = answer_q.pop_front();
        void'(answer_at.pop_front());
        check_field("distance", 32'(want.cost), 32'(out_distance));
        check_field("reachable", 32'(want.reach), 32'(out_reachable));
        check_field("next_vertex", 32'(want.hop), 32'(out_next_vertex));
        check_field("next_valid", 32'(want.hop_ok), 32'(out_next_valid));
      end
    end
  end

  always @(posedge clk) begin : watchdog_proc
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus_proc
    int a;
    int b;
    int w;
    int pick;
    for (int i = 0; i < apsp_pkg::NUM_VERTICES; i++) begin
      for (int j = 0; j < apsp_pkg::NUM_VERTICES; j++) begin
        edge_on[i][j]  = 1'b0;
        edge_len[i][j] = '0;
        path_on[i][j]  = 1'b0;
        path_len[i][j] = '0;
        path_hop[i][j] = '0;
      end
    end

    // Nothing is reachable before the first solve, not even a vertex from itself.
    push_req(apsp_pkg::REQ_QUERY, 0, 0, 0);
    push_req(apsp_pkg::REQ_QUERY, int'(apsp_pkg::VTX_LAST), int'(apsp_pkg::VTX_LAST), 65535);
    // A chain of heaviest edges gives the longest possible distance end to end.
    for (int v = 0; v < apsp_pkg::NUM_VERTICES - 1; v++)
      push_req(apsp_pkg::REQ_INSERT, v, v + 1, 65535);
    push_req(apsp_pkg::REQ_INSERT, 3, 3, 5);
    push_req(apsp_pkg::REQ_REMOVE, 5, 5, 0);
    push_req(apsp_pkg::REQ_INSERT, int'(apsp_pkg::VTX_LAST), 2, 0);
    push_req(apsp_pkg::REQ_REMOVE, 2, int'(apsp_pkg::VTX_LAST), 0);
    for (int c = int'(REQ_SPARE_LO); c <= int'(REQ_SPARE_HI); c++)
      push_req(3'(c), $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 65535));
    push_req(apsp_pkg::REQ_QUERY, 0, int'(apsp_pkg::VTX_LAST), 0);
    push_req(apsp_pkg::REQ_SOLVE, 0, 0, 0);
    push_req(apsp_pkg::REQ_QUERY, 0, int'(apsp_pkg::VTX_LAST), 0);
    push_req(apsp_pkg::REQ_QUERY, int'(apsp_pkg::VTX_LAST), 0, 0);
    push_req(apsp_pkg::REQ_QUERY, 4, 4, 0);
    push_req(apsp_pkg::REQ_DROP_V, 3, 6, 0);
    push_req(apsp_pkg::REQ_SOLVE, 0, 0, 0);
    push_req(apsp_pkg::REQ_QUERY, 0, int'(apsp_pkg::VTX_LAST), 0);
    push_req(apsp_pkg::REQ_QUERY, 4, 5, 0);

    while (request_q.size() < TARGET_REQUESTS) begin
      if ($urandom_range(0, 99) < 8) begin
        // Noise: spare codes, stray solves and queries, self edges.
        pick = $urandom_range(0, 3);
        a    = $urandom_range(0, 7);
        if (pick == 0)
          push_req(3'($urandom_range(int'(REQ_SPARE_LO), int'(REQ_SPARE_HI))), a,
                   $urandom_range(0, 7), $urandom_range(0, 65535));
        else if (pick == 1)
          push_req(apsp_pkg::REQ_SOLVE, a, $urandom_range(0, 7), $urandom_range(0, 65535));
        else if (pick == 2)
          push_req(apsp_pkg::REQ_QUERY, a, $urandom_range(0, 7), $urandom_range(0, 65535));
        else
          push_req($urandom_range(0, 1) ? apsp_pkg::REQ_INSERT : apsp_pkg::REQ_REMOVE, a, a,
                   $urandom_range(0, 65535));
      end else begin
        repeat ($urandom_range(1, 10)) begin
          a    = $urandom_range(0, 7);
          b    = $urandom_range(0, 7);
          while (b == a) b = $urandom_range(0, 7);
          pick = $urandom_range(0, 99);
          // Small weights make ties common, which tests the choice of next hop.
          case ($urandom_range(0, 9))
            0:       w = 0;
            1:       w = 65535;
            2, 3, 4: w = $urandom_range(0, 7);
            default: w = $urandom_range(0, 65535);
          endcase
          if (pick < 70)      push_req(apsp_pkg::REQ_INSERT, a, b, w);
          else if (pick < 92) push_req(apsp_pkg::REQ_REMOVE, a, b, w);
          else                push_req(apsp_pkg::REQ_DROP_V, a, b, w);
        end
        push_req(apsp_pkg::REQ_SOLVE, $urandom_range(0, 7), $urandom_range(0, 7),
                 $urandom_range(0, 65535));
        repeat ($urandom_range(2, 10)) begin
          a = $urandom_range(0, 7);
          b = ($urandom_range(0, 9) == 0) ? a : $urandom_range(0, 7);
          // An edit between solve and query must not change the answer.
          if ($urandom_range(0, 9) == 0)
            push_req(apsp_pkg::REQ_INSERT, a, $urandom_range(0, 7), $urandom_range(0, 65535));
          push_req(apsp_pkg::REQ_QUERY, a, b, $urandom_range(0, 65535));
        end
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || start) @(negedge clk);
    while (answer_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
